>>> sv/utf8_to_ucs2_stream_decoder_unit_defines.svh
// Assertion macros used by the checker file of the decoder.
`ifndef UTF8_TO_UCS2_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UCS2_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U2U_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("u2u assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U2U_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("u2u assertion failed");

`endif

>>> sv/u2u_pkg.sv
`default_nettype none
package u2u_pkg;

  localparam int unsigned TailDepth = 4;
  localparam int unsigned TailIdxW  = $clog2(TailDepth);

  localparam logic [2:0] SeqLenRaw  = 3'd1;
  localparam logic [2:0] SeqLenNone = 3'd0;
  localparam logic [7:0] ContMark   = 8'h80;

  typedef logic [5:0] payload_t;

endpackage
`default_nettype wire

>>> sv/utf8_to_ucs2_stream_decoder_unit.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_stall_o   | in_byte_i, end_of_text_i
// out     | output    | out_valid_o/out_stall_i | code_unit_o, seq_len_o, run_last_o
//
// One input transaction is taken per cycle while each byte gives at most one result and the output is not stalled.
// A byte that breaks or flushes a sequence gives up to six results, one per cycle while the output is not stalled.
// The result run register sets the rate; the input register holds one waiting byte.
// Reset clears the pending sequence and both registers; no clearing pass is needed.
// A stall on the output holds the current result and fills the input register.
`default_nettype none
module utf8_to_ucs2_stream_decoder_unit import u2u_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      code_unit_o,
  output logic [2:0]       seq_len_o,
  output logic             run_last_o
);

  logic           in_full_q, in_full_d;
  logic [7:0]     in_byte_q;
  logic           eot_q;

  logic [7:0]     lead_q, lead_d;
  logic [2:0]     exp_q, exp_d;
  logic [2:0]     cnt_q, cnt_d;
  logic [15:0]    acc_q, acc_d;
  payload_t       tail_q [TailDepth];
  payload_t       tail_d [TailDepth];

  logic [2:0]     rem_q, rem_d;
  logic [2:0]     pos_q, pos_d;
  logic           rflush_q, rflush_d;
  logic [2:0]     rk_q, rk_d;
  logic [7:0]     rlead_q;
  payload_t       rtail_q [TailDepth];
  logic           rx_d;
  logic [15:0]    rxcode_q, rxcode_d;
  logic [2:0]     rxlen_q, rxlen_d;

  logic           in_take, out_take, move;
  logic           pending, is_cont, fresh;
  payload_t       payload;
  logic [15:0]    acc_ext;
  logic [2:0]     f_len;
  logic [4:0]     f_bits;
  logic [2:0]     flush_n;
  logic [2:0]     tail_sel;

  assign out_valid_o = rem_q != 3'd0;
  assign out_take    = out_valid_o && !out_stall_i;
  assign move        = in_full_q && ((rem_q == 3'd0) || ((rem_q == 3'd1) && !out_stall_i));
  assign in_stall_o  = in_full_q && !move;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_full_d   = in_take || (in_full_q && !move);

  always_comb begin
    priority if (in_byte_q[7:5] == 3'b110) begin
      f_len  = 3'd2;
      f_bits = in_byte_q[4:0];
    end else if (in_byte_q[7:4] == 4'b1110) begin
      f_len  = 3'd3;
      f_bits = {1'b0, in_byte_q[3:0]};
    end else if (in_byte_q[7:3] == 5'b11110) begin
      f_len  = 3'd4;
      f_bits = {2'b0, in_byte_q[2:0]};
    end else if (in_byte_q[7:2] == 6'b111110) begin
      f_len  = 3'd5;
      f_bits = {3'b0, in_byte_q[1:0]};
    end else if (in_byte_q[7:1] == 7'b1111110) begin
      f_len  = 3'd6;
      f_bits = {4'b0, in_byte_q[0]};
    end else begin
      f_len  = SeqLenNone;
      f_bits = 5'd0;
    end
  end

  assign pending = exp_q != SeqLenNone;
  assign is_cont = in_byte_q[7:6] == 2'b10;
  assign payload = in_byte_q[5:0];
  assign acc_ext = {acc_q[9:0], payload};

  always_comb begin
    lead_d   = lead_q;
    exp_d    = exp_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    tail_d   = tail_q;
    rflush_d = 1'b0;
    rk_d     = cnt_q;
    rx_d     = 1'b0;
    rxcode_d = {8'd0, in_byte_q};
    rxlen_d  = SeqLenRaw;
    fresh    = !pending;
    if (pending) begin
      if (is_cont) begin
        acc_d = acc_ext;
        if (({1'b0, cnt_q} + 4'd2) >= {1'b0, exp_q}) begin
          rx_d     = 1'b1;
          rxcode_d = acc_ext;
          rxlen_d  = exp_q;
          exp_d    = SeqLenNone;
          cnt_d    = 3'd0;
        end else begin
          tail_d[cnt_q[TailIdxW-1:0]] = payload;
          cnt_d = cnt_q + 3'd1;
          if (eot_q) begin
            rflush_d = 1'b1;
            rk_d     = cnt_q + 3'd1;
            exp_d    = SeqLenNone;
            cnt_d    = 3'd0;
          end
        end
      end else begin
        rflush_d = 1'b1;
        exp_d    = SeqLenNone;
        cnt_d    = 3'd0;
        fresh    = 1'b1;
      end
    end
    if (fresh) begin
      if (f_len == SeqLenNone) begin
        rx_d = 1'b1;
      end else begin
        lead_d = in_byte_q;
        exp_d  = f_len;
        cnt_d  = 3'd0;
        acc_d  = {11'd0, f_bits};
        if (eot_q) begin
          rx_d  = 1'b1;
          exp_d = SeqLenNone;
        end
      end
    end
  end

  assign flush_n = rflush_q ? (rk_q + 3'd1) : 3'd0;
  assign tail_sel = pos_q - 3'd1;

  always_comb begin
    if (pos_q < flush_n) begin
      seq_len_o = SeqLenRaw;
      if (pos_q == 3'd0) begin
        code_unit_o = {8'd0, rlead_q};
      end else begin
        code_unit_o = {8'd0, ContMark | {2'b00, rtail_q[tail_sel[TailIdxW-1:0]]}};
      end
    end else begin
      code_unit_o = rxcode_q;
      seq_len_o   = rxlen_q;
    end
  end

  assign run_last_o = rem_q == 3'd1;

  always_comb begin
    rem_d = rem_q;
    pos_d = pos_q;
    if (move) begin
      rem_d = (rflush_d ? (rk_d + 3'd1) : 3'd0) + {2'b00, rx_d};
      pos_d = 3'd0;
    end else if (out_take) begin
      rem_d = rem_q - 3'd1;
      pos_d = pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
      exp_q     <= SeqLenNone;
      cnt_q     <= 3'd0;
      lead_q    <= 8'd0;
      acc_q     <= 16'd0;
      rem_q     <= 3'd0;
      pos_q     <= 3'd0;
    end else begin
      in_full_q <= in_full_d;
      rem_q     <= rem_d;
      pos_q     <= pos_d;
      if (move) begin
        exp_q  <= exp_d;
        cnt_q  <= cnt_d;
        lead_q <= lead_d;
        acc_q  <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
      eot_q     <= end_of_text_i;
    end
    if (move) begin
      tail_q   <= tail_d;
      rtail_q  <= tail_d;
      rlead_q  <= lead_q;
      rflush_q <= rflush_d;
      rk_q     <= rk_d;
      rxcode_q <= rxcode_d;
      rxlen_q  <= rxlen_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/u2u_checker.sv
`default_nettype none
`include "utf8_to_ucs2_stream_decoder_unit_defines.svh"
module u2u_checker import u2u_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [7:0]  in_byte_i,
  input wire logic        end_of_text_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] code_unit_o,
  input wire logic [2:0]  seq_len_o,
  input wire logic        run_last_o
);

  // A stalled result transaction keeps its payload.
  `U2U_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(code_unit_o) && $stable(seq_len_o) && $stable(run_last_o))

  `U2U_ASSERT_NOW(a_len_range, out_valid_o, (seq_len_o != SeqLenNone) && (seq_len_o != 3'd7))

  // A decoded character is always the only result of its byte.
  `U2U_ASSERT_NOW(a_decoded_alone, out_valid_o && (seq_len_o != SeqLenRaw), run_last_o)

  // Raw bytes never carry more than eight bits.
  `U2U_ASSERT_NOW(a_raw_narrow, out_valid_o && (seq_len_o == SeqLenRaw), code_unit_o[15:8] == 8'd0)

endmodule

bind utf8_to_ucs2_stream_decoder_unit u2u_checker u_u2u_checker (.*);
`default_nettype wire
